// ===== rtl/core/swpwt_pkg.sv =====
// ----------------------------------------------------------------------------
// swpwt_pkg
// Shared types and constants for the single-wire pulse-width transmitter.
// ----------------------------------------------------------------------------
package swpwt_pkg;

  // Frame buffer size and the widths of the fixed fields.
  localparam int BUFFER_BYTES_DEFAULT = 64;
  localparam int SYNC_W = 8;
  localparam int END_W  = 6;
  localparam int CFG_W  = 8;

  // Register reset values.
  localparam logic [SYNC_W-1:0] SYNC_LOW_RESET = 8'd30;
  localparam logic [END_W-1:0]  END_LOW_RESET  = 6'd12;

  // Register indexes on the configuration port.
  localparam logic REG_SYNC_LOW = 1'b0;
  localparam logic REG_END_LOW  = 1'b1;

  // Action codes of an input beat.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] byte_index;
    logic [7:0] byte_value;
    logic [6:0] frame_length;
  } in_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } out_t;

endpackage

// ===== rtl/core/swpwt_buffer.sv =====
// ----------------------------------------------------------------------------
// swpwt_buffer
// Frame byte store with one write port, one registered read port and a
// valid bit per entry; clearing the valid bits empties the whole buffer.
// ----------------------------------------------------------------------------
module swpwt_buffer #(
  parameter int DEPTH = swpwt_pkg::BUFFER_BYTES_DEFAULT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // An entry never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if ({1'b0, raddr} < (AW + 1)'(DEPTH) && valid[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      rdata <= '0;
    end
  end

endmodule

// ===== rtl/core/single_wire_pulse_width_transmitter.sv =====
// ----------------------------------------------------------------------------
// single_wire_pulse_width_transmitter
// Tick-driven single-wire frame transmitter: sync pulse, three-tick
// pulse-width bits MSB first, closing pulse, then a final tick.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        input      in_valid / in_ready        in_data  (swpwt_pkg::in_t)
// out       output     out_valid / out_ready      out_data (swpwt_pkg::out_t)
// cfg       input      cfg_write                  cfg_index, cfg_data
//
// Every input beat produces one result beat, registered in the cycle after acceptance; a new
// beat is taken every cycle while the result register is empty or being read.
// The buffer's registered read port tracks the current byte every cycle, so
// a bit's level is ready by the second tick of that bit.
// Synchronous reset clears the state and the buffer's valid bits and loads the
// registers' reset values. A stalled result holds the input side only when it is not taken.
// ----------------------------------------------------------------------------
module single_wire_pulse_width_transmitter #(
  parameter int BUFFER_BYTES = swpwt_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  swpwt_pkg::in_t               in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output swpwt_pkg::out_t              out_data,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [swpwt_pkg::CFG_W-1:0]  cfg_data
);

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int LW = $clog2(BUFFER_BYTES + 1);

  typedef enum logic [1:0] {PH_SYNC, PH_DATA, PH_CLOSE, PH_FINAL} phase_t;

  logic [swpwt_pkg::SYNC_W-1:0] sync_low_ticks;
  logic [swpwt_pkg::END_W-1:0]  end_low_ticks;

  phase_t                       phase, phase_next;
  logic [swpwt_pkg::SYNC_W-1:0] sync_count, sync_count_next;
  logic [swpwt_pkg::END_W-1:0]  tick_in_bit, tick_in_bit_next;
  logic [2:0]                   bit_position, bit_position_next;
  logic [LW-1:0]                byte_position, byte_position_next;
  logic [LW-1:0]                length_in_use, length_in_use_next;
  logic                         line_out, line_out_next;
  logic                         sending, sending_next;
  logic                         done_next;

  logic          in_fire;
  logic          buf_we;
  logic          buf_clear;
  logic [8:0]    index_ext;
  logic [8:0]    length_ext;
  logic [8:0]    length_sat;
  logic [LW-1:0] byte_inc;
  logic [7:0]    buf_rdata;

  assign in_ready   = !out_valid || out_ready;
  assign in_fire    = in_valid && in_ready;
  assign index_ext  = 9'(in_data.byte_index);
  assign length_ext = 9'(in_data.frame_length);
  assign length_sat = (length_ext > 9'(BUFFER_BYTES)) ? 9'(BUFFER_BYTES) : length_ext;
  assign byte_inc   = byte_position + 1'b1;

  swpwt_buffer #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_buffer (
    .clk   (clk),
    .rst   (rst),
    .clear (buf_clear),
    .we    (buf_we),
    .waddr (index_ext[AW-1:0]),
    .wdata (in_data.byte_value),
    .raddr (byte_position[AW-1:0]),
    .rdata (buf_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_low_ticks <= swpwt_pkg::SYNC_LOW_RESET;
      end_low_ticks  <= swpwt_pkg::END_LOW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        swpwt_pkg::REG_SYNC_LOW: sync_low_ticks <= cfg_data;
        swpwt_pkg::REG_END_LOW:  end_low_ticks  <= cfg_data[swpwt_pkg::END_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next         = phase;
    sync_count_next    = sync_count;
    tick_in_bit_next   = tick_in_bit;
    bit_position_next  = bit_position;
    byte_position_next = byte_position;
    length_in_use_next = length_in_use;
    line_out_next      = line_out;
    sending_next       = sending;
    done_next          = 1'b0;
    buf_we             = 1'b0;
    buf_clear          = 1'b0;
    if (in_fire) begin
      unique case (in_data.action)
        swpwt_pkg::ACT_TICK: begin
          if (sending) begin
            unique case (phase)
              PH_SYNC: begin
                if (sync_count < sync_low_ticks) begin
                  line_out_next   = 1'b0;
                  sync_count_next = sync_count + 1'b1;
                end else begin
                  line_out_next      = 1'b1;
                  phase_next         = PH_DATA;
                  sync_count_next    = '0;
                  tick_in_bit_next   = '0;
                  bit_position_next  = 3'd7;
                  byte_position_next = '0;
                end
              end
              PH_DATA: begin
                if (tick_in_bit == '0) begin
                  line_out_next    = 1'b0;
                  tick_in_bit_next = swpwt_pkg::END_W'(1);
                end else if (tick_in_bit == swpwt_pkg::END_W'(1)) begin
                  line_out_next    = buf_rdata[bit_position];
                  tick_in_bit_next = swpwt_pkg::END_W'(2);
                end else begin
                  line_out_next    = 1'b1;
                  tick_in_bit_next = '0;
                  if (bit_position == 3'd0) begin
                    bit_position_next  = 3'd7;
                    byte_position_next = byte_inc;
                    if (byte_inc >= length_in_use) begin
                      phase_next = PH_CLOSE;
                    end
                  end else begin
                    bit_position_next = bit_position - 1'b1;
                  end
                end
              end
              PH_CLOSE: begin
                if (tick_in_bit < end_low_ticks) begin
                  line_out_next    = 1'b0;
                  tick_in_bit_next = tick_in_bit + 1'b1;
                end else begin
                  line_out_next = 1'b1;
                  phase_next    = PH_FINAL;
                end
              end
              PH_FINAL: begin
                line_out_next      = 1'b0;
                buf_clear          = 1'b1;
                length_in_use_next = '0;
                sending_next       = 1'b0;
                phase_next         = PH_SYNC;
                sync_count_next    = '0;
                tick_in_bit_next   = '0;
                bit_position_next  = 3'd7;
                byte_position_next = '0;
                done_next          = 1'b1;
              end
              default: ;
            endcase
          end
        end
        swpwt_pkg::ACT_WRITE: begin
          buf_we = !sending && (index_ext < 9'(BUFFER_BYTES));
        end
        swpwt_pkg::ACT_START: begin
          if (!sending && in_data.frame_length != '0) begin
            length_in_use_next = length_sat[LW-1:0];
            sending_next       = 1'b1;
            phase_next         = PH_SYNC;
            sync_count_next    = '0;
            tick_in_bit_next   = '0;
            bit_position_next  = 3'd7;
            byte_position_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC;
      sync_count    <= '0;
      tick_in_bit   <= '0;
      bit_position  <= 3'd7;
      byte_position <= '0;
      length_in_use <= '0;
      line_out      <= 1'b0;
      sending       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      sync_count    <= sync_count_next;
      tick_in_bit   <= tick_in_bit_next;
      bit_position  <= bit_position_next;
      byte_position <= byte_position_next;
      length_in_use <= length_in_use_next;
      line_out      <= line_out_next;
      sending       <= sending_next;
      if (in_fire) begin
        out_valid           <= 1'b1;
        out_data.line_level <= line_out_next;
        out_data.busy_res   <= sending_next;
        out_data.frame_done <= done_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A finishing beat always reports the block as no longer busy.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> !out_data.busy_res)
    else $error("frame_done reported while busy");

  // While bits are being sent the current byte lies inside the frame.
  assert property (@(posedge clk) disable iff (rst)
    sending && phase == PH_DATA |-> byte_position < length_in_use)
    else $error("byte position outside the frame during data");

  // An idle block sits at the start of a frame with the counters cleared.
  assert property (@(posedge clk) disable iff (rst)
    !sending |-> phase == PH_SYNC && byte_position == '0 && length_in_use == '0)
    else $error("idle block with frame state left over");

  // Only a tick beat in the final phase can end a frame.
  assert property (@(posedge clk) disable iff (rst)
    $fell(sending) |-> $past(phase) == PH_FINAL)
    else $error("frame ended outside the final phase");

endmodule
